>>> src/rfmc_pkg.sv
// ----------------------------------------------------------------------------
// rfmc_pkg
// shared types and constants of the randomized prim maze carver
// ----------------------------------------------------------------------------
package rfmc_pkg;

  localparam int GRID_COLS      = 48;
  localparam int GRID_ROWS      = 32;
  localparam int FRONTIER_DEPTH = 512;

  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int FA_W   = $clog2(FRONTIER_DEPTH);
  localparam int CNT_W  = $clog2(FRONTIER_DEPTH + 1);
  localparam int BX_W   = 7;
  localparam int BY_W   = 7;
  localparam int CC_W   = 8;
  localparam int RND_W  = 32;
  localparam int DIV_CW = $clog2(RND_W);

  typedef struct packed {
    logic             opcode;
    logic [RND_W-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [6:0] wall_x;
    logic [5:0] wall_y;
    logic       carved;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    logic [BX_W-1:0] x;
    logic [BY_W-1:0] y;
  } wall_t;

  typedef enum logic [1:0] {DIR_W, DIR_S, DIR_E, DIR_N} dir_t;

  typedef enum logic [1:0] {VS_A, VS_B, VS_NB, VS_TGT} vsel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RDP, S_RDL, S_POP, S_RDA, S_CHA, S_RDB, S_CHB,
    S_NB_RD, S_NB_CHK, S_MK_RD, S_MK_WR, S_FIN
  } state_t;

  typedef struct packed {
    logic  cap_in;
    logic  clear;
    logic  div_step;
    logic  rd_pos;
    logic  rd_last;
    logic  cap_w;
    logic  pop;
    logic  rd_vis;
    vsel_t vsel;
    logic  cap_a;
    logic  sel_target;
    logic  chk_nb;
    logic  mark;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic count_zero;
    logic div_last;
    logic dir_last;
    logic carve;
  } sts_t;

endpackage

>>> src/rfmc_datapath.sv
// ----------------------------------------------------------------------------
// rfmc_datapath
// visited map, frontier store, modulo unit and result register
// ----------------------------------------------------------------------------
module rfmc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rfmc_pkg::in_item_t in_data,
  input  rfmc_pkg::cmd_t     cmd,
  output rfmc_pkg::sts_t     sts,
  output rfmc_pkg::out_item_t out_data
);
  import rfmc_pkg::*;

  logic [GRID_COLS-1:0] vmem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid;
  logic [GRID_COLS-1:0] row_q;
  logic                 row_ok_q;
  wall_t                fmem [FRONTIER_DEPTH];
  wall_t                fr_q;

  logic [RND_W-1:0]  rnd_sh;
  logic [CNT_W-1:0]  rem;
  logic [DIV_CW-1:0] div_cnt;
  logic [CNT_W-1:0]  count;
  wall_t             w;
  logic              va_q;
  logic [COL_W-1:0]  tcx;
  logic [ROW_W-1:0]  tcy;
  dir_t              dir;
  logic              has_wall;
  logic              carved;
  logic              done_flag;

  logic [CNT_W:0]       div_t;
  logic [CNT_W-1:0]     cnt_m1;
  logic [GRID_COLS-1:0] row_eff;
  logic                 odd;
  logic [CC_W-1:0]      wx8, wy8, acx, acy, bcx, bcy;
  logic                 a_oob, b_oob, va_now, vb_now;
  logic [CC_W-1:0]      tcx8, tcy8, ncx, ncy;
  logic                 n_ok, nb_vis, push_ok;
  wall_t                nb_wall;
  logic [ROW_W-1:0]     vaddr;
  logic [FA_W-1:0]      faddr;

  assign div_t   = {rem, rnd_sh[RND_W-1]};
  assign cnt_m1  = count - CNT_W'(1);
  assign row_eff = row_ok_q ? row_q : '0;

  // cells on the two sides of the popped wall
  always_comb begin
    odd = w.x[0];
    wx8 = CC_W'(w.x);
    wy8 = CC_W'(w.y);
    acx = wx8 >> 1;
    bcx = odd ? (wx8 >> 1) + CC_W'(1) : (wx8 >> 1);
    acy = odd ? (wy8 >> 1) : ((wy8 - CC_W'(1)) >> 1);
    bcy = odd ? (wy8 >> 1) : ((wy8 + CC_W'(1)) >> 1);
    a_oob = (!odd && w.y == '0) || acx >= CC_W'(GRID_COLS) || acy >= CC_W'(GRID_ROWS);
    b_oob = bcx >= CC_W'(GRID_COLS) || bcy >= CC_W'(GRID_ROWS);
    va_now = a_oob || row_eff[acx[COL_W-1:0]];
    vb_now = b_oob || row_eff[bcx[COL_W-1:0]];
  end

  // neighbor of the cell being marked
  always_comb begin
    tcx8 = CC_W'(tcx);
    tcy8 = CC_W'(tcy);
    ncx  = tcx8;
    ncy  = tcy8;
    n_ok = 1'b0;
    nb_wall.x = BX_W'(tcx8 << 1);
    nb_wall.y = BY_W'(tcy8 << 1);
    unique case (dir)
      DIR_W: begin
        n_ok = tcx8 != '0;
        ncx = tcx8 - CC_W'(1);
        nb_wall.x = BX_W'((tcx8 << 1) - CC_W'(1));
      end
      DIR_S: begin
        ncy = tcy8 + CC_W'(1);
        n_ok = ncy < CC_W'(GRID_ROWS);
        nb_wall.y = BY_W'((tcy8 << 1) + CC_W'(1));
      end
      DIR_E: begin
        ncx = tcx8 + CC_W'(1);
        n_ok = ncx < CC_W'(GRID_COLS);
        nb_wall.x = BX_W'((tcx8 << 1) + CC_W'(1));
      end
      DIR_N: begin
        n_ok = tcy8 != '0;
        ncy = tcy8 - CC_W'(1);
        nb_wall.y = BY_W'((tcy8 << 1) - CC_W'(1));
      end
      default: n_ok = 1'b0;
    endcase
    nb_vis  = row_eff[ncx[COL_W-1:0]];
    push_ok = n_ok && !nb_vis && count < CNT_W'(FRONTIER_DEPTH);
  end

  always_comb begin
    unique case (cmd.vsel)
      VS_A:    vaddr = acy[ROW_W-1:0];
      VS_B:    vaddr = bcy[ROW_W-1:0];
      VS_NB:   vaddr = ncy[ROW_W-1:0];
      VS_TGT:  vaddr = tcy;
      default: vaddr = tcy;
    endcase
    faddr = cmd.rd_pos ? rem[FA_W-1:0] : cnt_m1[FA_W-1:0];
  end

  // visited map
  always_ff @(posedge clk) begin
    if (cmd.rd_vis) begin
      row_q    <= vmem[vaddr];
      row_ok_q <= row_valid[vaddr];
    end
    if (cmd.mark) begin
      vmem[tcy] <= row_eff | (GRID_COLS'(1) << tcx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.clear) begin
      row_valid <= '0;
    end else if (cmd.mark) begin
      row_valid[tcy] <= 1'b1;
    end
  end

  // frontier store
  always_ff @(posedge clk) begin
    if (cmd.rd_pos || cmd.rd_last) begin
      fr_q <= fmem[faddr];
    end
    if (cmd.pop) begin
      fmem[rem[FA_W-1:0]] <= fr_q;
    end else if (cmd.chk_nb && push_ok) begin
      fmem[count[FA_W-1:0]] <= nb_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.pop) begin
      count <= cnt_m1;
    end else if (cmd.chk_nb && push_ok) begin
      count <= count + CNT_W'(1);
    end
  end

  // restoring remainder, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      rnd_sh  <= in_data.random_word;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rnd_sh  <= rnd_sh << 1;
      div_cnt <= div_cnt + DIV_CW'(1);
      if (div_t >= {1'b0, count}) begin
        rem <= CNT_W'(div_t - {1'b0, count});
      end else begin
        rem <= div_t[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      has_wall  <= 1'b0;
      carved    <= 1'b0;
      done_flag <= in_data.opcode && count == '0;
    end
    if (cmd.cap_w) begin
      w        <= fr_q;
      has_wall <= 1'b1;
    end
    if (cmd.cap_a) begin
      va_q <= va_now;
    end
    if (cmd.clear) begin
      tcx <= '0;
      tcy <= '0;
      dir <= DIR_W;
    end else if (cmd.sel_target) begin
      carved <= va_q ^ vb_now;
      dir    <= DIR_W;
      if (!va_q) begin
        tcx <= acx[COL_W-1:0];
        tcy <= acy[ROW_W-1:0];
      end else begin
        tcx <= bcx[COL_W-1:0];
        tcy <= bcy[ROW_W-1:0];
      end
    end else if (cmd.chk_nb) begin
      dir <= dir_t'(2'(dir + 2'd1));
    end
    if (cmd.out_load) begin
      out_data.wall_x   <= has_wall ? w.x : '0;
      out_data.wall_y   <= has_wall ? w.y[5:0] : '0;
      out_data.carved   <= carved;
      out_data.done_res <= done_flag;
    end
  end

  assign sts.opcode     = in_data.opcode;
  assign sts.count_zero = count == '0;
  assign sts.div_last   = div_cnt == DIV_CW'(RND_W - 1);
  assign sts.dir_last   = dir == DIR_N;
  assign sts.carve      = va_q ^ vb_now;

endmodule

>>> src/rfmc_ctrl.sv
// ----------------------------------------------------------------------------
// rfmc_ctrl
// sequencer for start and carve beats, owns the handshakes
// ----------------------------------------------------------------------------
module rfmc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rfmc_pkg::sts_t sts,
  output rfmc_pkg::cmd_t cmd
);
  import rfmc_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!sts.opcode) state_next = S_NB_RD;
          else if (sts.count_zero) state_next = S_FIN;
          else state_next = S_DIV;
        end
      end
      S_DIV:    if (sts.div_last) state_next = S_RDP;
      S_RDP:    state_next = S_RDL;
      S_RDL:    state_next = S_POP;
      S_POP:    state_next = S_RDA;
      S_RDA:    state_next = S_CHA;
      S_CHA:    state_next = S_RDB;
      S_RDB:    state_next = S_CHB;
      S_CHB:    state_next = sts.carve ? S_NB_RD : S_FIN;
      S_NB_RD:  state_next = S_NB_CHK;
      S_NB_CHK: state_next = sts.dir_last ? S_MK_RD : S_NB_RD;
      S_MK_RD:  state_next = S_MK_WR;
      S_MK_WR:  state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.vsel = VS_TGT;
    unique case (state)
      S_IDLE: begin
        cmd.cap_in = in_valid;
        cmd.clear  = in_valid && !sts.opcode;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_RDP: cmd.rd_pos = 1'b1;
      S_RDL: begin
        cmd.cap_w   = 1'b1;
        cmd.rd_last = 1'b1;
      end
      S_POP: cmd.pop = 1'b1;
      S_RDA: begin
        cmd.rd_vis = 1'b1;
        cmd.vsel   = VS_A;
      end
      S_CHA: cmd.cap_a = 1'b1;
      S_RDB: begin
        cmd.rd_vis = 1'b1;
        cmd.vsel   = VS_B;
      end
      S_CHB: cmd.sel_target = 1'b1;
      S_NB_RD: begin
        cmd.rd_vis = 1'b1;
        cmd.vsel   = VS_NB;
      end
      S_NB_CHK: cmd.chk_nb = 1'b1;
      S_MK_RD:  cmd.rd_vis = 1'b1;
      S_MK_WR:  cmd.mark = 1'b1;
      S_FIN:    cmd.out_load = out_free;
      default:  cmd.cap_in = 1'b0;
    endcase
  end

endmodule

>>> src/random_frontier_maze_carver.sv
// ----------------------------------------------------------------------------
// random_frontier_maze_carver
// randomized prim maze carver with a swap-remove frontier list
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A start beat (opcode 0) clears the visited
// map and frontier, marks cell (0,0) and pushes its frontier walls, and
// answers with all fields zero. A carve beat (opcode 1) first takes the
// bit-serial remainder of random_word by the frontier count; the rest of it
// is single-port reads of the frontier store and the visited map and, when
// the wall is opened, one check of each neighbor of the newly marked cell.
// On an empty frontier a carve beat answers done_res at once. One beat is
// worked on at a time; the result waits in an output register so a stalled
// consumer only delays the next beat's finish, not its acceptance.
// ----------------------------------------------------------------------------
module random_frontier_maze_carver (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rfmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rfmc_pkg::out_item_t out_data
);
  import rfmc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  rfmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // visited map, frontier store, remainder unit, result register
  rfmc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> src/rfmc_checker.sv
// ----------------------------------------------------------------------------
// rfmc_checker
// port-level checks on the maze carver, bound to the top level
// ----------------------------------------------------------------------------
module rfmc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rfmc_pkg::out_item_t out_data
);
  import rfmc_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one beat at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  // done carries no wall
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |->
      !out_data.carved && out_data.wall_x == '0 && out_data.wall_y == '0)
    else $error("done beat with wall data");

  // a carved wall sits between two cells
  a_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.carved |-> out_data.wall_x[0] != out_data.wall_y[0])
    else $error("carved position is not a wall");

endmodule

bind random_frontier_maze_carver rfmc_checker u_rfmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
